// ===== rtl/phlm_pkg.sv =====
// ----------------------------------------------------------------------------
// Peak-hold level meter package
// Zone codes, configuration register indexes and reset values shared by the
// level meter.
// ----------------------------------------------------------------------------
`default_nettype none

package phlm_pkg;

  typedef enum logic [1:0] {
    ZONE_NORMAL = 2'd0,
    ZONE_WARN   = 2'd1,
    ZONE_CRIT   = 2'd2
  } zone_e;

  typedef enum logic [2:0] {
    CFG_RANGE_LOW    = 3'd0,
    CFG_RANGE_HIGH   = 3'd1,
    CFG_WARN_LEVEL   = 3'd2,
    CFG_CRIT_LEVEL   = 3'd3,
    CFG_HYST_PERCENT = 3'd4,
    CFG_HOLD_TIME_MS = 3'd5,
    CFG_TRACKING_ON  = 3'd6
  } cfg_idx_e;

  localparam int RST_RANGE_LOW  = 0;
  localparam int RST_RANGE_HIGH = 10000;
  localparam int RST_WARN_LEVEL = 6500;
  localparam int RST_CRIT_LEVEL = 8500;

  localparam logic [6:0]  RST_HYST_PERCENT = 7'd0;
  localparam logic [15:0] RST_HOLD_TIME_MS = 16'd1000;

  // The decay step span * 15 / 1000 equals (span * 3 / 8) / 25.
  localparam int STEP_DEN = 25;

  localparam int HYST_SCALE = 100;

endpackage

`default_nettype wire

// ===== rtl/peak_hold_level_meter.sv =====
// ----------------------------------------------------------------------------
// Peak-hold level meter
// Clamps samples to the display range, tracks a three-zone state with
// hysteresis and holds and decays the peak on timer ticks.
// ----------------------------------------------------------------------------
// The meter accepts one word per clock cycle unless its input is stalled: a
// word is registered on entry and its result word is registered when the
// word advances to the output. While a result word waits at a stalled output,
// one more word can be taken into the input register before the input stalls.
// After reset and after every write to range_low or range_high the input is
// stalled while the decay step (span * 15 / 1000) is recomputed by a reciprocal
// multiplication; a write to warn_level, crit_level or hyst_percent stalls it
// while the zone is re-evaluated on the current value.
`default_nettype none

module peak_hold_level_meter #(
  parameter int unsigned TICK_MS    = 40,
  parameter int unsigned VALUE_BITS = 16,
  localparam int unsigned CfgW      = (VALUE_BITS > 16) ? VALUE_BITS : 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,

  input  wire                          cfg_we_i,
  input  wire  [2:0]                   cfg_idx_i,
  input  wire  [CfgW-1:0]              cfg_wdata_i,

  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire                          func_i,
  input  wire  signed [VALUE_BITS-1:0] sample_i,

  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic signed [VALUE_BITS-1:0] shown_value_o,
  output logic [1:0]                   zone_o,
  output logic signed [VALUE_BITS-1:0] peak_level_o,
  output logic [1:0]                   peak_zone_o,
  output logic                         holding_o,
  output logic                         decay_running_o
);

  localparam int VB    = VALUE_BITS;
  localparam int LvW   = VB + 1;
  localparam int DW    = VB + 2;
  localparam int PW    = VB + 9;
  localparam int SpW   = VB + 2;
  localparam int RecSh = VB + 4;
  localparam int QW    = VB - 5;

  localparam logic signed [PW-1:0] Hundred = PW'(phlm_pkg::HYST_SCALE);
  localparam logic signed [DW-1:0] VMaxD   = DW'({1'b0, {(VB-1){1'b1}}});
  localparam logic signed [DW-1:0] VMinD   = -VMaxD - DW'(1);
  localparam logic [15:0]          Tick16  = 16'(TICK_MS);
  localparam logic [VB-1:0]        StepRecip =
    VB'(((64'd1 << RecSh) + 64'(phlm_pkg::STEP_DEN) - 64'd1) /
        64'(phlm_pkg::STEP_DEN));

  function automatic logic [VB-1:0] mag_f(input logic signed [VB-1:0] x);
    return x[VB-1] ? (~x + VB'(1)) : x;
  endfunction

  function automatic logic signed [LvW-1:0] level_f(input logic bip,
                                                    input logic signed [VB-1:0] x);
    return bip ? {1'b0, mag_f(x)} : {x[VB-1], x};
  endfunction

  function automatic logic signed [VB-1:0] sat_f(input logic signed [DW-1:0] x);
    logic signed [VB-1:0] r;
    if (x > VMaxD) begin
      r = VMaxD[VB-1:0];
    end else if (x < VMinD) begin
      r = VMinD[VB-1:0];
    end else begin
      r = x[VB-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic signed [VB-1:0] lo_q, hi_q, warn_q, crit_q;
  logic [6:0]           hyst_q;
  logic [15:0]          hold_time_q;
  logic                 track_q;

  // Meter state.
  logic signed [VB-1:0] cur_q, cur_d, peak_q, peak_d;
  phlm_pkg::zone_e      zone_q, zone_d;
  logic [15:0]          hold_q, hold_d;
  logic                 decay_q, decay_d;
  logic                 rezone_q, rezone_d;

  // Input and result registers.
  logic                 s1_valid_q, s1_func_q;
  logic signed [VB-1:0] s1_sample_q;
  logic                 out_valid_q;
  logic signed [VB-1:0] out_value_q, out_peak_q;
  phlm_pkg::zone_e      out_zone_q, out_pzone_q;
  logic                 out_hold_q, out_decay_q;

  // Decay step.
  logic                 step_load_q;
  logic [VB-1:0]        step_q;

  logic busy, out_free, adv, in_acc, cfg_rezone, cfg_untrack, cfg_range;

  assign busy     = rezone_q || step_load_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign adv      = s1_valid_q && out_free && !busy;
  assign in_stall_o = busy || (s1_valid_q && !adv);
  assign in_acc   = in_valid_i && !in_stall_o;

  assign cfg_rezone = cfg_we_i &&
                      (cfg_idx_i == phlm_pkg::CFG_WARN_LEVEL ||
                       cfg_idx_i == phlm_pkg::CFG_CRIT_LEVEL ||
                       cfg_idx_i == phlm_pkg::CFG_HYST_PERCENT);
  assign cfg_untrack = cfg_we_i && (cfg_idx_i == phlm_pkg::CFG_TRACKING_ON) &&
                       track_q && !cfg_wdata_i[0];
  assign cfg_range = cfg_we_i && (cfg_idx_i == phlm_pkg::CFG_RANGE_LOW ||
                                  cfg_idx_i == phlm_pkg::CFG_RANGE_HIGH);

  // Range and thresholds.
  logic                  bipolar;
  logic signed [VB-1:0]  wlo, chi, clamp_v, zin;
  logic [VB-1:0]         mm;
  logic signed [PW-1:0]  lv100, wl100, ch100, h100, mm_s, hy_s;
  phlm_pkg::zone_e       zone_nx, pzone_nx;
  logic signed [LvW-1:0] lv_pk;

  assign bipolar = lo_q[VB-1] && !hi_q[VB-1] && (hi_q != '0);
  assign wlo     = (warn_q < crit_q) ? warn_q : crit_q;
  assign chi     = (warn_q < crit_q) ? crit_q : warn_q;
  assign mm      = (mag_f(lo_q) > mag_f(hi_q)) ? mag_f(lo_q) : mag_f(hi_q);

  always_comb begin
    clamp_v = s1_sample_q;
    if (clamp_v < lo_q) begin
      clamp_v = lo_q;
    end
    if (clamp_v > hi_q) begin
      clamp_v = hi_q;
    end
  end

  assign zin   = rezone_q ? cur_q : clamp_v;
  assign lv100 = PW'(level_f(bipolar, zin)) * Hundred;
  assign wl100 = PW'(wlo) * Hundred;
  assign ch100 = PW'(chi) * Hundred;
  assign mm_s  = PW'({1'b0, mm});
  assign hy_s  = PW'({1'b0, hyst_q});
  assign h100  = mm_s * hy_s;

  always_comb begin
    case (zone_q)
      phlm_pkg::ZONE_NORMAL: begin
        if (lv100 >= ch100) begin
          zone_nx = phlm_pkg::ZONE_CRIT;
        end else if (lv100 >= wl100) begin
          zone_nx = phlm_pkg::ZONE_WARN;
        end else begin
          zone_nx = phlm_pkg::ZONE_NORMAL;
        end
      end
      phlm_pkg::ZONE_WARN: begin
        if (lv100 >= ch100) begin
          zone_nx = phlm_pkg::ZONE_CRIT;
        end else if (lv100 < wl100 - h100) begin
          zone_nx = phlm_pkg::ZONE_NORMAL;
        end else begin
          zone_nx = phlm_pkg::ZONE_WARN;
        end
      end
      phlm_pkg::ZONE_CRIT: begin
        if (lv100 < ch100 - h100) begin
          zone_nx = (lv100 >= wl100) ? phlm_pkg::ZONE_WARN : phlm_pkg::ZONE_NORMAL;
        end else begin
          zone_nx = phlm_pkg::ZONE_CRIT;
        end
      end
      default: begin
        zone_nx = phlm_pkg::ZONE_NORMAL;
      end
    endcase
  end

  // One decay step of the peak toward the current value.
  logic signed [DW-1:0] cur_m, pk_b, dec_b, sv_b, step_s, pk_u, max_u;
  logic                 neg_b;
  logic signed [VB-1:0] decay_v;

  always_comb begin
    step_s = DW'({1'b0, step_q});
    cur_m  = DW'({1'b0, mag_f(cur_q)});
    pk_b   = DW'({1'b0, mag_f(peak_q)}) - step_s;
    dec_b  = (cur_m > pk_b) ? cur_m : pk_b;
    neg_b  = (cur_m >= dec_b) ? cur_q[VB-1] : peak_q[VB-1];
    sv_b   = neg_b ? -dec_b : dec_b;
    pk_u   = DW'(peak_q) - step_s;
    max_u  = (DW'(cur_q) > pk_u) ? DW'(cur_q) : pk_u;
    decay_v = bipolar ? sat_f(sv_b) : sat_f(max_u);
  end

  always_comb begin
    cur_d   = cur_q;
    peak_d  = peak_q;
    zone_d  = zone_q;
    hold_d  = hold_q;
    decay_d = decay_q;
    if (rezone_q) begin
      zone_d = zone_nx;
    end else if (adv) begin
      if (!s1_func_q) begin
        cur_d  = clamp_v;
        zone_d = zone_nx;
        if (track_q) begin
          if (mag_f(clamp_v) > mag_f(peak_q)) begin
            peak_d = clamp_v;
            hold_d = hold_time_q;
          end
          decay_d = 1'b1;
        end
      end else if (decay_q) begin
        if (hold_q != '0) begin
          hold_d = (hold_q > Tick16) ? hold_q - Tick16 : '0;
        end else begin
          peak_d  = decay_v;
          decay_d = (level_f(bipolar, decay_v) != level_f(bipolar, cur_q));
        end
      end
    end
    if (cfg_untrack) begin
      decay_d = 1'b0;
      hold_d  = '0;
      peak_d  = cur_q;
    end
  end

  assign lv_pk = level_f(bipolar, peak_d);

  always_comb begin
    if (lv_pk >= LvW'(chi)) begin
      pzone_nx = phlm_pkg::ZONE_CRIT;
    end else if (lv_pk >= LvW'(wlo)) begin
      pzone_nx = phlm_pkg::ZONE_WARN;
    end else begin
      pzone_nx = phlm_pkg::ZONE_NORMAL;
    end
  end

  assign rezone_d = cfg_rezone;

  // Decay step: the span times three, shifted right by three, then divided
  // by 25 through a multiplication with the rounded-up reciprocal.
  logic signed [DW-1:0] span_s;
  logic [VB-1:0]        span_u;
  logic [SpW-1:0]       span3;
  logic [2*VB-2:0]      step_prod;
  logic [QW-1:0]        step_quo;
  logic [VB-1:0]        step_calc;

  assign span_s    = DW'(hi_q) - DW'(lo_q);
  assign span_u    = (span_s > DW'(0)) ? span_s[VB-1:0] : '0;
  assign span3     = SpW'(span_u) + SpW'({span_u, 1'b0});
  assign step_prod = span3[SpW-1:3] * StepRecip;
  assign step_quo  = step_prod[2*VB-2:RecSh];
  assign step_calc = (step_quo == '0) ? VB'(1) : VB'(step_quo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_load_q <= 1'b1;
      step_q      <= VB'(1);
    end else begin
      step_load_q <= cfg_range;
      if (step_load_q) begin
        step_q <= step_calc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q        <= VB'(phlm_pkg::RST_RANGE_LOW);
      hi_q        <= VB'(phlm_pkg::RST_RANGE_HIGH);
      warn_q      <= VB'(phlm_pkg::RST_WARN_LEVEL);
      crit_q      <= VB'(phlm_pkg::RST_CRIT_LEVEL);
      hyst_q      <= phlm_pkg::RST_HYST_PERCENT;
      hold_time_q <= phlm_pkg::RST_HOLD_TIME_MS;
      track_q     <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        phlm_pkg::CFG_RANGE_LOW:    lo_q        <= cfg_wdata_i[VB-1:0];
        phlm_pkg::CFG_RANGE_HIGH:   hi_q        <= cfg_wdata_i[VB-1:0];
        phlm_pkg::CFG_WARN_LEVEL:   warn_q      <= cfg_wdata_i[VB-1:0];
        phlm_pkg::CFG_CRIT_LEVEL:   crit_q      <= cfg_wdata_i[VB-1:0];
        phlm_pkg::CFG_HYST_PERCENT: hyst_q      <= cfg_wdata_i[6:0];
        phlm_pkg::CFG_HOLD_TIME_MS: hold_time_q <= cfg_wdata_i[15:0];
        phlm_pkg::CFG_TRACKING_ON:  track_q     <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      peak_q      <= '0;
      zone_q      <= phlm_pkg::ZONE_NORMAL;
      hold_q      <= '0;
      decay_q     <= 1'b0;
      rezone_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      peak_q      <= peak_d;
      zone_q      <= zone_d;
      hold_q      <= hold_d;
      decay_q     <= decay_d;
      rezone_q    <= rezone_d;
      s1_valid_q  <= in_acc || (s1_valid_q && !adv);
      out_valid_q <= adv || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q   <= func_i;
      s1_sample_q <= sample_i;
    end
    if (adv) begin
      out_value_q <= cur_d;
      out_zone_q  <= zone_d;
      out_peak_q  <= peak_d;
      out_pzone_q <= pzone_nx;
      out_hold_q  <= (hold_d != '0);
      out_decay_q <= decay_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign shown_value_o   = out_value_q;
  assign zone_o          = out_zone_q;
  assign peak_level_o    = out_peak_q;
  assign peak_zone_o     = out_pzone_q;
  assign holding_o       = out_hold_q;
  assign decay_running_o = out_decay_q;

endmodule

`default_nettype wire
